FILE: sv/cgla_pkg.sv
// ----------------------------------------------------------------------------
// cgla_pkg
// Shared constants and cell control type for the commit graph lane allocator.
// ----------------------------------------------------------------------------
package cgla_pkg;

  localparam int KEY_W           = 64;  // commit / parent key width
  localparam int NPF             = 4;   // parent key fields per item
  localparam int PIW             = 2;   // index into the parent fields
  localparam int PCNT_W          = 3;   // parent_count width
  localparam int COL_OUT_W       = 4;   // reported column width
  localparam int MASK_OUT_W      = 16;  // reported mask width
  localparam int COLUMNS_DEF     = 16;
  localparam int MAX_PARENTS_DEF = 4;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             match_en;    // match phase of an accepted item
    logic             start;       // clear row; column 0 stands for this commit
    logic [KEY_W-1:0] commit_key;
    logic             place_en;    // one parent placement this cycle
    logic [KEY_W-1:0] parent_key;
  } cgla_ctl_t;

endpackage

FILE: sv/commit_graph_lane_allocator_unit.sv
// ----------------------------------------------------------------------------
// commit_graph_lane_allocator_unit
// Lane allocator for commit graphs: a row of column cells tracks awaited keys.
// ----------------------------------------------------------------------------
// Flow: key match on accept, commit column in S_COL, then one placement step per
//   parent in S_PLACE (count limited to MAX_PARENTS and to four; a dropped parent
//   takes its step too), then the result register loads once the output is free.
//   New items wait for S_IDLE; the free-slot seek places one parent per cycle.
// Reset: synchronous, active low; clears all slot busy flags, the sequencer
//   and the output valid. Keys are not reset; a free slot's key never shows.

module commit_graph_lane_allocator_unit
  import cgla_pkg::*;
#(
  parameter int COLUMNS     = COLUMNS_DEF,
  parameter int MAX_PARENTS = MAX_PARENTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, lowest bit up: start_req[0], commit_key[64:1], parent_count[67:65],
  //   parent_key_0[131:68], parent_key_1[195:132], parent_key_2[259:196],
  //   parent_key_3[323:260], zero fill [327:324]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [327:0] in_tdata,
  // out_tdata, lowest bit up: matched_mask[15:0], commit_column[19:16],
  //   passthrough_mask[35:20], parent_column_0[39:36], parent_column_1[43:40],
  //   parent_column_2[47:44], parent_column_3[51:48], parent_placed[55:52],
  //   not_found[56], zero fill [63:57]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata
);

  localparam int CW = $clog2(COLUMNS);
  localparam int XW = (CW > COL_OUT_W) ? CW : COL_OUT_W;
  localparam int MW = (COLUMNS > MASK_OUT_W) ? COLUMNS : MASK_OUT_W;
  // effective parent limit: parameter and the four key fields
  localparam int PN = (MAX_PARENTS < NPF) ? MAX_PARENTS : NPF;

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for an item; accept does the key match
    S_COL,    // lowest hit -> commit column, capture passthrough
    S_PLACE   // one parent per cycle, then load the output register
  } state_t;

  // --------------------------------------------------------------------------
  // Input field unpack
  // --------------------------------------------------------------------------
  logic              in_start;
  logic [KEY_W-1:0]  in_commit_key;
  logic [PCNT_W-1:0] in_parent_count;
  logic [KEY_W-1:0]  in_pkey [NPF];

  assign in_start        = in_tdata[0];
  assign in_commit_key   = in_tdata[64:1];
  assign in_parent_count = in_tdata[67:65];
  assign in_pkey[0]      = in_tdata[131:68];
  assign in_pkey[1]      = in_tdata[195:132];
  assign in_pkey[2]      = in_tdata[259:196];
  assign in_pkey[3]      = in_tdata[323:260];

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  state_t            state_r;
  logic [PCNT_W-1:0] cnt_r;        // parents to place
  logic [PCNT_W-1:0] idx_r;        // next parent to place
  logic [KEY_W-1:0]  pkey_r [NPF];
  logic [COLUMNS-1:0] matched_r;
  logic [COLUMNS-1:0] pass_r;
  logic [CW-1:0]     col_r;
  logic              found_r;
  logic [CW-1:0]     pcol_r [NPF];
  logic [NPF-1:0]    placed_r;
  logic              out_valid_r;
  logic [63:0]       out_data_r;

  logic in_accept;
  logic place_step;
  logic out_free;
  logic load_done;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid & in_tready;
  assign place_step = (state_r == S_PLACE) && (idx_r < cnt_r);
  assign out_free   = ~out_valid_r | out_tready;
  assign load_done  = (state_r == S_PLACE) && (idx_r == cnt_r) && out_free;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  cgla_ctl_t          ctl;
  logic [COLUMNS:0]   seek;        // seek[i] enters cell i
  logic [COLUMNS-1:0] hit_vec;
  logic [COLUMNS-1:0] take_vec;
  logic [COLUMNS-1:0] busy_vec;
  logic [COLUMNS-1:0] elig_vec;

  always_comb begin
    ctl.match_en   = in_accept;
    ctl.start      = in_start;
    ctl.commit_key = in_commit_key;
    ctl.place_en   = place_step;
    ctl.parent_key = pkey_r[idx_r[PIW-1:0]];
  end

  assign seek[0] = 1'b1;

  for (genvar i = 0; i < COLUMNS; i++) begin : g_cell
    assign elig_vec[i] = (CW'(i) >= col_r);

    cgla_cell #(
      .FIRST (i == 0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .eligible (elig_vec[i]),
      .seek_in  (seek[i]),
      .seek_out (seek[i+1]),
      .hit      (hit_vec[i]),
      .take     (take_vec[i]),
      .busy     (busy_vec[i])
    );
  end

  // --------------------------------------------------------------------------
  // Lowest hit and taken slot -> column index (one-hot encode)
  // --------------------------------------------------------------------------
  logic [COLUMNS-1:0] first_hit;
  logic [CW-1:0]      first_col;
  logic [CW-1:0]      take_col;

  assign first_hit = matched_r & (~matched_r + COLUMNS'(1));

  always_comb begin
    first_col = '0;
    take_col  = '0;
    for (int i = 0; i < COLUMNS; i++) begin
      if (first_hit[i]) first_col = first_col | CW'(i);
      if (take_vec[i])  take_col  = take_col  | CW'(i);
    end
  end

  // column and mask reporting: low bits only
  function automatic logic [COL_OUT_W-1:0] col_out(input logic [CW-1:0] c);
    logic [XW-1:0] w;
    w = XW'(c);
    return w[COL_OUT_W-1:0];
  endfunction

  function automatic logic [MASK_OUT_W-1:0] mask_out(input logic [COLUMNS-1:0] m);
    logic [MW-1:0] w;
    w = MW'(m);
    return w[MASK_OUT_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // State machine and registered outputs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace the one leaving this cycle
      if (load_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            matched_r <= hit_vec;
            cnt_r     <= (in_parent_count > PCNT_W'(PN)) ? PCNT_W'(PN) : in_parent_count;
            idx_r     <= '0;
            placed_r  <= '0;
            for (int p = 0; p < NPF; p++) begin
              pkey_r[p] <= in_pkey[p];
              pcol_r[p] <= '0;
            end
            state_r <= S_COL;
          end
        end
        S_COL: begin
          col_r   <= first_col;      // zero when nothing matched
          found_r <= |matched_r;
          pass_r  <= busy_vec;       // row after matched slots freed
          state_r <= S_PLACE;
        end
        S_PLACE: begin
          if (place_step) begin
            if (|take_vec) begin
              pcol_r[idx_r[PIW-1:0]]   <= take_col;
              placed_r[idx_r[PIW-1:0]] <= 1'b1;
            end
            idx_r <= idx_r + PCNT_W'(1);
          end else if (load_done) begin
            out_data_r  <= {7'b0, ~found_r, placed_r,
                            col_out(pcol_r[3]), col_out(pcol_r[2]),
                            col_out(pcol_r[1]), col_out(pcol_r[0]),
                            mask_out(pass_r), col_out(col_r), mask_out(matched_r)};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // a placement claims at most one slot
  a_take_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(take_vec))
    else $error("more than one cell took a parent");

  // a freed slot cannot also be reported as passthrough
  a_pass_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    load_done |-> ((matched_r & pass_r) == '0))
    else $error("matched column also reported as passthrough");

  // no parent beyond the effective count is marked placed
  a_placed_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_done |-> ((placed_r >> cnt_r) == '0))
    else $error("placed bit beyond parent count");

  // the sequencer leaves idle only through an accepted item
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_accept) |=> (state_r == S_IDLE))
    else $error("sequencer left idle without an item");
`endif

endmodule

FILE: sv/cgla_cell.sv
// ----------------------------------------------------------------------------
// cgla_cell
// One column slot: busy flag and awaited key, key match, free-slot seek.
// ----------------------------------------------------------------------------
module cgla_cell
  import cgla_pkg::*;
#(
  parameter bit FIRST = 1'b0   // column 0 takes the seed on start
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cgla_ctl_t ctl,
  input  logic      eligible,  // column at or above the commit column
  input  logic      seek_in,   // no lower eligible free slot taken yet
  output logic      seek_out,
  output logic      hit,
  output logic      take,
  output logic      busy
);

  logic             busy_r;
  logic [KEY_W-1:0] key_r;

  // On start the seeded key matches itself at once, so column 0 just hits.
  assign hit      = ctl.match_en &
                    (ctl.start ? FIRST : (busy_r & (key_r == ctl.commit_key)));
  assign take     = ctl.place_en & seek_in & eligible & ~busy_r;
  assign seek_out = seek_in & ~take;
  assign busy     = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.match_en) begin
      busy_r <= ~ctl.start & busy_r & ~hit;
    end else if (take) begin
      busy_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= ctl.parent_key;
    end
  end

endmodule
